>>> hw/rtl/wcmix_pkg.sv
// Shared constants and register codes for the weighted CMYK color mix core.
// No dependencies; every other file but wcmix_div takes names from here by scope.
package wcmix_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int CH_W = 8;
	localparam int WT_W = 8;
	localparam int IDX_W = 2;
	localparam int SUM_W = WT_W + 1;

	localparam logic [IDX_W-1:0] REG_WEIGHT_FIRST = 2'd0;
	localparam logic [IDX_W-1:0] REG_WEIGHT_SECOND = 2'd1;

	localparam logic [CH_W-1:0] CH_MAX = 8'd255;
	localparam logic [WT_W-1:0] WT_RESET = 8'd1;

endpackage

>>> hw/rtl/wcmix_if.sv
// Valid/ready channel interfaces: color pair request, mixed result, register write.
// Depends on wcmix_pkg for field widths.
interface wcmix_pair_if;
	logic valid;
	logic ready;
	logic [wcmix_pkg::CH_W-1:0] first_red;
	logic [wcmix_pkg::CH_W-1:0] first_green;
	logic [wcmix_pkg::CH_W-1:0] first_blue;
	logic [wcmix_pkg::CH_W-1:0] second_red;
	logic [wcmix_pkg::CH_W-1:0] second_green;
	logic [wcmix_pkg::CH_W-1:0] second_blue;
	modport source (output valid, first_red, first_green, first_blue,
		second_red, second_green, second_blue, input ready);
	modport sink (input valid, first_red, first_green, first_blue,
		second_red, second_green, second_blue, output ready);
endinterface

interface wcmix_mixed_if;
	logic valid;
	logic ready;
	logic [wcmix_pkg::CH_W-1:0] mixed_red;
	logic [wcmix_pkg::CH_W-1:0] mixed_green;
	logic [wcmix_pkg::CH_W-1:0] mixed_blue;
	logic weight_sum_zero;
	modport source (output valid, mixed_red, mixed_green, mixed_blue, weight_sum_zero,
		input ready);
	modport sink (input valid, mixed_red, mixed_green, mixed_blue, weight_sum_zero,
		output ready);
endinterface

interface wcmix_cfg_if;
	logic valid;
	logic ready;
	logic [wcmix_pkg::IDX_W-1:0] index;
	logic [wcmix_pkg::WT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/wcmix_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// Depends on nothing but its parameters; used twice by the top level.
module wcmix_div #(
	parameter int LANES = 4,
	parameter int DW = 8,
	parameter int QW = 17,
	parameter int SBW = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [DW+QW-1:0]      num [LANES],
	input  logic [DW-1:0]         den [LANES],
	input  logic [SBW-1:0]        sb_in,
	output logic                  out_vld,
	output logic [QW-1:0]         quo [LANES],
	output logic [SBW-1:0]        sb_out
);

	logic [DW-1:0] rem_s [QW][LANES];
	logic [QW-1:0] low_s [QW][LANES];
	logic [QW-1:0] quo_s [QW][LANES];
	logic [DW-1:0] den_s [QW][LANES];
	logic [SBW-1:0] sb_s [QW];
	logic vld_s [QW];

	logic [DW-1:0] rem_nxt [QW][LANES];
	logic [QW-1:0] low_nxt [QW][LANES];
	logic [QW-1:0] quo_nxt [QW][LANES];
	logic [DW-1:0] den_nxt [QW][LANES];

	// one shift-compare-subtract per stage
	always_comb begin
		logic [DW-1:0] r;
		logic [QW-1:0] lo;
		logic [QW-1:0] q;
		logic [DW-1:0] d;
		logic [DW:0] t;
		logic ge;
		for (int g = 0; g < QW; g++) begin
			for (int l = 0; l < LANES; l++) begin
				if (g == 0) begin
					r = num[l][DW+QW-1:QW];
					lo = num[l][QW-1:0];
					q = '0;
					d = den[l];
				end else begin
					r = rem_s[(g == 0) ? 0 : g-1][l];
					lo = low_s[(g == 0) ? 0 : g-1][l];
					q = quo_s[(g == 0) ? 0 : g-1][l];
					d = den_s[(g == 0) ? 0 : g-1][l];
				end
				t = {r, lo[QW-1]};
				ge = (t >= {1'b0, d});
				rem_nxt[g][l] = ge ? DW'(t - {1'b0, d}) : t[DW-1:0];
				low_nxt[g][l] = {lo[QW-2:0], 1'b0};
				quo_nxt[g][l] = {q[QW-2:0], ge};
				den_nxt[g][l] = d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s <= rem_nxt;
			low_s <= low_nxt;
			quo_s <= quo_nxt;
			den_s <= den_nxt;
			for (int g = 0; g < QW; g++) begin
				sb_s[g] <= (g == 0) ? sb_in : sb_s[(g == 0) ? 0 : g-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < QW; g++) vld_s[g] <= 1'b0;
		end else if (en) begin
			for (int g = 0; g < QW; g++) begin
				vld_s[g] <= (g == 0) ? in_vld : vld_s[(g == 0) ? 0 : g-1];
			end
		end
	end

	assign out_vld = vld_s[QW-1];
	assign quo = quo_s[QW-1];
	assign sb_out = sb_s[QW-1];

endmodule

>>> hw/rtl/wcmix_back.sv
// Back conversion CMYK to RGB: two stages, product of the white shares, then scale by 255.
// Depends on wcmix_pkg for channel width.
module wcmix_back #(
	parameter int FB = wcmix_pkg::FRACTION_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic [FB:0]                mix [4],
	input  logic                       flag,
	output logic                       out_vld,
	output logic [wcmix_pkg::CH_W-1:0] rgb [3],
	output logic                       flag_out
);

	localparam int PW = 2 * FB + 2;
	localparam int SW = PW + wcmix_pkg::CH_W;
	localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

	logic [PW-1:0] prod_s1 [3];
	logic flag_s1, vld_s1;
	logic [wcmix_pkg::CH_W-1:0] rgb_s2 [3];
	logic flag_s2, vld_s2;
	logic [SW-1:0] scaled [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			scaled[i] = {prod_s1[i], {wcmix_pkg::CH_W{1'b0}}} - SW'(prod_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= PW'((ONE - mix[i]) * (ONE - mix[3]));
				rgb_s2[i] <= scaled[i][2*FB+wcmix_pkg::CH_W-1:2*FB];
			end
			flag_s1 <= flag;
			flag_s2 <= flag_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	assign out_vld = vld_s2;
	assign rgb = rgb_s2;
	assign flag_out = flag_s2;

endmodule

>>> hw/rtl/weighted_cmyk_color_mix_core.sv
// Top level of the weighted CMYK color mix core.
// Depends on wcmix_pkg, wcmix_if, wcmix_div and wcmix_back.

// Mixes two 8-bit RGB colors through CMYK with two programmable weights. Each
// color becomes four inks (C, M, Y as (max-channel)/max, K as (255-max)/255,
// a black color giving zero CMY), the inks are averaged with weight_first and
// weight_second (both zero: equal weights and weight_sum_zero set), and the
// result goes back to RGB as floor(255*(1-ink)*(1-k)). All fractions carry
// FRACTION_BITS bits and truncate. Throughput is one request per cycle while
// the result side does not stall; the pipeline has 2*FRACTION_BITS+5
// register stages (17+1+17+2 = 37 at the default of 16): FRACTION_BITS+1
// stages of the ink divider (the key is formed by a reciprocal multiply and
// rides beside it), one weighting multiply stage, FRACTION_BITS+1 stages of
// the averaging divider and two stages of back conversion. A stall on the
// result side holds the whole pipeline; bubbles are not squeezed out. Registers:
// index 0 weight_first, index 1 weight_second, both reset to 1; writes to other
// indexes are dropped. Write registers only while the pipeline is empty.
module weighted_cmyk_color_mix_core #(
	parameter int FRACTION_BITS = wcmix_pkg::FRACTION_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	wcmix_pair_if.sink     pair,
	wcmix_mixed_if.source  mixed,
	wcmix_cfg_if.sink      cfg
);

	localparam int FB = FRACTION_BITS;
	localparam int QW = FB + 1;
	localparam int CW = wcmix_pkg::CH_W;
	localparam int WW = wcmix_pkg::WT_W;
	localparam int SW = wcmix_pkg::SUM_W;
	localparam int PW = WW + QW;
	localparam logic [QW-1:0] ONE = {1'b1, {FB{1'b0}}};
	// key = floor(x * 2^FB / 255) = (x * KEY_RECIP) >> KEY_SHIFT for x up to 255
	localparam int KEY_SHIFT = 16;
	localparam int KPW = CW + FB + 9;
	localparam logic [FB+8:0] KEY_RECIP =
		(FB+9)'(((64'd1 << (FB + KEY_SHIFT)) + 64'd254) / 64'd255);

	logic [WW-1:0] weight_first_q, weight_second_q;
	logic en;

	// Register writes; always ready.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_first_q <= wcmix_pkg::WT_RESET;
			weight_second_q <= wcmix_pkg::WT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				wcmix_pkg::REG_WEIGHT_FIRST: weight_first_q <= cfg.data;
				wcmix_pkg::REG_WEIGHT_SECOND: weight_second_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Advance every stage unless the result register is full and not taken.
	assign en = !mixed.valid || mixed.ready;
	assign pair.ready = en;

	// Ink numerators and divisors: lanes 0..2 first color, 3..5 second.
	logic [CW-1:0] ch [2][3];
	logic [CW-1:0] mx [2];
	logic [CW+QW-1:0] num1 [6];
	logic [CW-1:0] den1 [6];
	logic [KPW-1:0] key_prod [2];
	logic [QW-1:0] key [2];
	logic both_zero;

	assign ch[0][0] = pair.first_red;
	assign ch[0][1] = pair.first_green;
	assign ch[0][2] = pair.first_blue;
	assign ch[1][0] = pair.second_red;
	assign ch[1][1] = pair.second_green;
	assign ch[1][2] = pair.second_blue;
	assign both_zero = (weight_first_q == '0) && (weight_second_q == '0);

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			mx[c] = ch[c][0];
			if (ch[c][1] > mx[c]) mx[c] = ch[c][1];
			if (ch[c][2] > mx[c]) mx[c] = ch[c][2];
			for (int i = 0; i < 3; i++) begin
				// black color: zero numerator over a safe divisor gives zero ink
				if (mx[c] == '0) begin
					num1[3*c+i] = '0;
					den1[3*c+i] = wcmix_pkg::CH_MAX;
				end else begin
					num1[3*c+i] = {1'b0, mx[c] - ch[c][i], {FB{1'b0}}};
					den1[3*c+i] = mx[c];
				end
			end
			// key by reciprocal multiply; exact over the whole 8-bit range
			key_prod[c] = KPW'(wcmix_pkg::CH_MAX - mx[c]) * KPW'(KEY_RECIP);
			key[c] = key_prod[c][KPW-1:KEY_SHIFT];
		end
	end

	logic ink_vld;
	logic [QW-1:0] ink [6];
	logic [2*QW:0] ink_sb;
	logic ink_flag;
	logic [QW-1:0] key_a, key_b;

	wcmix_div #(.LANES(6), .DW(CW), .QW(QW), .SBW(2*QW+1)) u_ink_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(pair.valid),
		.num(num1), .den(den1), .sb_in({key[1], key[0], both_zero}),
		.out_vld(ink_vld), .quo(ink), .sb_out(ink_sb)
	);

	assign ink_flag = ink_sb[0];
	assign key_a = ink_sb[QW:1];
	assign key_b = ink_sb[2*QW:QW+1];

	// Weighting stage: hold each ink times its weight and the weight sum.
	logic [WW-1:0] w1_eff, w2_eff;
	logic [PW-1:0] prod_a_s1 [4], prod_b_s1 [4];
	logic [SW-1:0] sum_s1;
	logic flag_s1, vld_s1;

	assign w1_eff = ink_flag ? wcmix_pkg::WT_RESET : weight_first_q;
	assign w2_eff = ink_flag ? wcmix_pkg::WT_RESET : weight_second_q;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_a_s1[i] <= PW'(w1_eff * ink[i]);
				prod_b_s1[i] <= PW'(w2_eff * ink[3+i]);
			end
			prod_a_s1[3] <= PW'(w1_eff * key_a);
			prod_b_s1[3] <= PW'(w2_eff * key_b);
			sum_s1 <= SW'(w1_eff) + SW'(w2_eff);
			flag_s1 <= ink_flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= ink_vld;
		end
	end

	// Weighted average: (w1*ink1 + w2*ink2) / (w1 + w2).
	logic [SW+QW-1:0] num2 [4];
	logic [SW-1:0] den2 [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			num2[i] = (SW+QW)'(prod_a_s1[i]) + (SW+QW)'(prod_b_s1[i]);
			den2[i] = sum_s1;
		end
	end

	logic avg_vld;
	logic [QW-1:0] avg [4];
	logic avg_flag;

	wcmix_div #(.LANES(4), .DW(SW), .QW(QW), .SBW(1)) u_avg_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s1),
		.num(num2), .den(den2), .sb_in(flag_s1),
		.out_vld(avg_vld), .quo(avg), .sb_out(avg_flag)
	);

	// Back to RGB; the last stage is the result register.
	logic [CW-1:0] rgb [3];

	wcmix_back #(.FB(FB)) u_back (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(avg_vld),
		.mix(avg), .flag(avg_flag),
		.out_vld(mixed.valid), .rgb(rgb), .flag_out(mixed.weight_sum_zero)
	);

	assign mixed.mixed_red = rgb[0];
	assign mixed.mixed_green = rgb[1];
	assign mixed.mixed_blue = rgb[2];

	// Key and averaged inks never exceed one.
	a_ink_range: assert property (@(posedge clk) disable iff (!arst_n)
		ink_vld |-> (key_a <= ONE) && (key_b <= ONE))
		else $error("key fraction above one");

	a_avg_range: assert property (@(posedge clk) disable iff (!arst_n)
		avg_vld |-> (avg[0] <= ONE) && (avg[3] <= ONE))
		else $error("averaged ink above one");

	// User keeps weights static while items are in flight; the flag needs it.
	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		mixed.valid |-> (mixed.weight_sum_zero == both_zero))
		else $error("weight_sum_zero disagrees with weights");

endmodule

>>> test/weighted_cmyk_color_mix_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the weighted CMYK color mix core.
// Depends on wcmix_pkg, the wcmix channel interfaces and the core itself.
module weighted_cmyk_color_mix_core_tb;

	localparam int FB = wcmix_pkg::FRACTION_BITS_DEF;
	localparam int LATENCY = 2 * FB + 5;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [wcmix_pkg::CH_W-1:0] r1, g1, b1, r2, g2, b2;
	} color_pair_t;

	typedef struct packed {
		logic [wcmix_pkg::CH_W-1:0] red, green, blue;
		logic sum_zero;
	} mixed_color_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	wcmix_pair_if pair ();
	wcmix_mixed_if mixed ();
	wcmix_cfg_if cfg ();

	weighted_cmyk_color_mix_core uut (
		.clk(clk), .arst_n(arst_n), .pair(pair.sink), .mixed(mixed.source), .cfg(cfg.sink)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Local copies of the weight registers, updated on each accepted write.
	logic [wcmix_pkg::WT_W-1:0] wt_first = wcmix_pkg::WT_RESET;
	logic [wcmix_pkg::WT_W-1:0] wt_second = wcmix_pkg::WT_RESET;

	mixed_color_t mix_queue[$];
	int errors = 0;
	int idle_cycles = 0;
	bit rx_busy = 0;

	// CMYK of one color: three inks and key, each with FB fraction bits.
	function automatic void color_to_inks(input logic [wcmix_pkg::CH_W-1:0] r, g, b,
		output logic [63:0] ink[4]);
		logic [63:0] mx;
		logic [63:0] ch[3];
		ch[0] = 64'(r); ch[1] = 64'(g); ch[2] = 64'(b);
		mx = 64'(r);
		if (64'(g) > mx) mx = 64'(g);
		if (64'(b) > mx) mx = 64'(b);
		for (int i = 0; i < 3; i++)
			ink[i] = (mx == 0) ? 64'd0 : ((mx - ch[i]) << FB) / mx;
		ink[3] = ((64'd255 - mx) << FB) / 64'd255;
	endfunction

	function automatic mixed_color_t predict_mix(color_pair_t p);
		logic [63:0] ia[4], ib[4], avg[4], w1, w2, one, prod;
		logic [7:0] out[3];
		mixed_color_t m;
		one = 64'd1 << FB;
		color_to_inks(p.r1, p.g1, p.b1, ia);
		color_to_inks(p.r2, p.g2, p.b2, ib);
		w1 = 64'(wt_first); w2 = 64'(wt_second);
		m.sum_zero = 1'b0;
		if (w1 + w2 == 0) begin
			w1 = 64'd1; w2 = 64'd1; m.sum_zero = 1'b1;
		end
		for (int i = 0; i < 4; i++)
			avg[i] = (w1 * ia[i] + w2 * ib[i]) / (w1 + w2);
		for (int i = 0; i < 3; i++) begin
			prod = (one - avg[i]) * (one - avg[3]);
			out[i] = 8'((64'd255 * prod) >> (2 * FB));
		end
		m.red = out[0]; m.green = out[1]; m.blue = out[2];
		return m;
	endfunction

	// Watchdog: count cycles with no accepted transfer on any channel.
	always @(posedge clk) begin
		if ((pair.valid && pair.ready) || (mixed.valid && mixed.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result checker: compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && mixed.valid && mixed.ready) begin
			mixed_color_t want;
			if (mix_queue.size() == 0) begin
				$error("unexpected result red=%0d green=%0d blue=%0d",
					mixed.mixed_red, mixed.mixed_green, mixed.mixed_blue);
				errors++;
			end else begin
				want = mix_queue.pop_front();
				if (mixed.mixed_red !== want.red) begin
					$error("mixed_red expected %0d actual %0d", want.red, mixed.mixed_red);
					errors++;
				end
				if (mixed.mixed_green !== want.green) begin
					$error("mixed_green expected %0d actual %0d", want.green, mixed.mixed_green);
					errors++;
				end
				if (mixed.mixed_blue !== want.blue) begin
					$error("mixed_blue expected %0d actual %0d", want.blue, mixed.mixed_blue);
					errors++;
				end
				if (mixed.weight_sum_zero !== want.sum_zero) begin
					$error("weight_sum_zero expected %0d actual %0d", want.sum_zero,
						mixed.weight_sum_zero);
					errors++;
				end
			end
		end
	end

	// Receiver stall pattern: alternate between ready stretches and stalls of
	// random lengths, with some phases of the run fully ready.
	initial begin
		int run;
		mixed.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (run > 0) begin
				run--;
			end else if (rx_busy) begin
				mixed.ready <= ~mixed.ready;
				run = mixed.ready ? $urandom_range(0, 3) : $urandom_range(0, 12);
			end else begin
				mixed.ready <= 1'b1;
			end
		end
	end

	// Sender burst shaping: gap cycles left before the next request.
	int gap_left = 0;
	int burst_left = 0;
	bit bursty = 1;

	// Drive one request and hold it until accepted; record the prediction.
	task automatic send_pair(color_pair_t p);
		if (bursty && burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap_left = $urandom_range(0, 6);
		end
		while (gap_left > 0) begin
			pair.valid <= 1'b0;
			@(posedge clk);
			gap_left--;
		end
		pair.valid <= 1'b1;
		{pair.first_red, pair.first_green, pair.first_blue,
			pair.second_red, pair.second_green, pair.second_blue} <= p;
		do @(posedge clk); while (!pair.ready);
		mix_queue.push_back(predict_mix(p));
		if (burst_left > 0) burst_left--;
	endtask

	task automatic release_pair();
		pair.valid <= 1'b0;
	endtask

	// Wait for the pipeline to drain before a register write or the end.
	task automatic drain();
		release_pair();
		while (mix_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Hold the write request until accepted; the caller drops valid.
	task automatic write_reg(logic [wcmix_pkg::IDX_W-1:0] idx,
		logic [wcmix_pkg::WT_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		if (idx == wcmix_pkg::REG_WEIGHT_FIRST) wt_first = value;
		else if (idx == wcmix_pkg::REG_WEIGHT_SECOND) wt_second = value;
	endtask

	task automatic set_weights(logic [wcmix_pkg::WT_W-1:0] w1,
		logic [wcmix_pkg::WT_W-1:0] w2);
		drain();
		write_reg(wcmix_pkg::REG_WEIGHT_FIRST, w1);
		write_reg(wcmix_pkg::REG_WEIGHT_SECOND, w2);
		cfg.valid <= 1'b0;
	endtask

	function automatic color_pair_t random_pair();
		color_pair_t p;
		p = 48'({$urandom, $urandom});
		// Skew some channels toward black, white and ties between two channels.
		case ($urandom_range(0, 5))
			0: {p.r1, p.g1, p.b1} = '0;
			1: {p.r2, p.g2, p.b2} = '1;
			2: p.g1 = p.r1;
			default: ;
		endcase
		return p;
	endfunction

	// Extremes, black and white inputs, pure and gray colors at reset weights.
	task automatic test_directed_colors();
		color_pair_t list[] = '{
			{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
			{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
			{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255},
			{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255},
			{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0},
			{8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1},
			{8'd128, 8'd128, 8'd128, 8'd127, 8'd64, 8'd1},
			{8'd254, 8'd1, 8'd170, 8'd85, 8'd85, 8'd86},
			{8'd255, 8'd254, 8'd253, 8'd0, 8'd0, 8'd0},
			{8'd170, 8'd85, 8'd0, 8'd3, 8'd2, 8'd1}
		};
		bursty = 0;
		foreach (list[i]) send_pair(list[i]);
		bursty = 1;
	endtask

	// Weight extremes, including the zero-sum fallback and one-sided weights.
	task automatic test_weight_extremes();
		logic [wcmix_pkg::WT_W-1:0] wl[6][2] = '{'{8'd0, 8'd0}, '{8'd255, 8'd0},
			'{8'd0, 8'd255}, '{8'd255, 8'd255}, '{8'd1, 8'd255}, '{8'd255, 8'd1}};
		foreach (wl[i]) begin
			set_weights(wl[i][0], wl[i][1]);
			send_pair({8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255});
			send_pair({8'd0, 8'd0, 8'd0, 8'd200, 8'd100, 8'd50});
		end
	endtask

	// Random pairs over unit, random and zero weight settings, fully ready phase first.
	task automatic test_random_mix();
		for (int phase = 0; phase < 8; phase++) begin
			if (phase == 0) set_weights(8'd1, 8'd1);
			else if (phase == 7) set_weights(8'd0, 8'd0);
			else set_weights(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			rx_busy = (phase != 0);
			bursty = (phase != 1);
			repeat (90) send_pair(random_pair());
		end
		rx_busy = 1;
	endtask

	initial begin
		pair.valid = 1'b0;
		{pair.first_red, pair.first_green, pair.first_blue,
			pair.second_red, pair.second_green, pair.second_blue} = '0;
		cfg.valid = 1'b0;
		cfg.index = wcmix_pkg::REG_WEIGHT_FIRST;
		cfg.data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_colors();
		test_weight_extremes();
		test_random_mix();
		drain();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
